// ----- hdl/upc_pkg.sv -----
// Package: shared types, character constants and helpers for the URL percent codec.
`timescale 1ns / 1ps
`default_nettype none

package upc_pkg;

   // Most result bytes one input byte can produce
   localparam int unsigned SLOTS   = 3;
   localparam int unsigned COUNT_W = 2;
   localparam int unsigned CSR_INDEX_W = 2;

   // Register indexes on the csr channel
   localparam logic [CSR_INDEX_W-1:0] REG_DECODE_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_UPPER_HEX   = 2'd1;

   localparam logic [7:0] CHAR_PERCENT    = 8'h25;
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] CHAR_DASH       = 8'h2D;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_TILDE      = 8'h7E;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       bad;
   } result_type;

   // Up to three results for one input byte; count is how many are used
   typedef struct packed {
      result_type [SLOTS-1:0] slot;
      logic [COUNT_W-1:0]     count;
   } bundle_type;

   function automatic logic is_digit(input logic [7:0] x);
      return (x >= 8'h30) && (x <= 8'h39);
   endfunction

   function automatic logic is_hex(input logic [7:0] x);
      return is_digit(x) || ((x >= 8'h41) && (x <= 8'h46)) ||
             ((x >= 8'h61) && (x <= 8'h66));
   endfunction

   // Only meaningful for hex characters
   function automatic logic [3:0] hex_value(input logic [7:0] x);
      return is_digit(x) ? x[3:0] : 4'(x[3:0] + 4'd9);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      logic [7:0] base;
      base = upper ? 8'h37 : 8'h57;
      return (nib < 4'd10) ? {4'h3, nib} : 8'(base + {4'h0, nib});
   endfunction

   function automatic logic passes_plain(input logic [7:0] x);
      return is_digit(x) || ((x >= 8'h41) && (x <= 8'h5A)) ||
             ((x >= 8'h61) && (x <= 8'h7A)) || (x == CHAR_DOT) ||
             (x == CHAR_DASH) || (x == CHAR_UNDERSCORE) || (x == CHAR_TILDE);
   endfunction

   // Plain decode: '%' opens an escape and emits nothing, '+' becomes space
   function automatic logic plain_emits(input logic [7:0] x);
      return x != CHAR_PERCENT;
   endfunction

   function automatic logic [7:0] plain_byte(input logic [7:0] x);
      return (x == CHAR_PLUS) ? CHAR_SPACE : x;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/upc_front.sv -----
// Front end: config registers, escape tracking and per-byte result bundling.
`timescale 1ns / 1ps
`default_nettype none

module upc_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic [7:0]                          req_in_byte,
   input  wire logic                                req_in_last,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [upc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic                                csr_data,
   input  wire logic                                q_full,
   output logic                                     q_push,
   output upc_pkg::bundle_type                      q_bundle
);

   localparam logic [1:0] PH_NONE    = 2'd0;
   localparam logic [1:0] PH_PERCENT = 2'd1;
   localparam logic [1:0] PH_DIGIT   = 2'd2;

   logic       decode_ff, upper_ff;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       accept;

   upc_pkg::result_type       slot_c [upc_pkg::SLOTS];
   logic [upc_pkg::COUNT_W-1:0] n_c;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_ff <= 1'b0;
         upper_ff  <= 1'b1;
      end else if (csr_valid) begin
         if (csr_index == upc_pkg::REG_DECODE_MODE) decode_ff <= csr_data;
         if (csr_index == upc_pkg::REG_UPPER_HEX)   upper_ff  <= csr_data;
      end
   end

   always_comb begin
      for (int i = 0; i < upc_pkg::SLOTS; i++) slot_c[i] = '0;
      n_c      = '0;
      phase_in = PH_NONE;
      held_in  = held_ff;
      if (!decode_ff) begin
         if (upc_pkg::passes_plain(req_in_byte)) begin
            slot_c[0].data = req_in_byte;
            n_c = 2'd1;
         end else begin
            slot_c[0].data = upc_pkg::CHAR_PERCENT;
            slot_c[1].data = upc_pkg::hex_char(req_in_byte[7:4], upper_ff);
            slot_c[2].data = upc_pkg::hex_char(req_in_byte[3:0], upper_ff);
            n_c = 2'd3;
         end
      end else begin
         case (phase_ff)
            PH_PERCENT: begin
               if (upc_pkg::is_hex(req_in_byte)) begin
                  held_in  = req_in_byte;
                  phase_in = PH_DIGIT;
               end else begin
                  slot_c[0].data = upc_pkg::CHAR_PERCENT;
                  slot_c[0].bad  = 1'b1;
                  n_c = 2'd1;
                  if (upc_pkg::plain_emits(req_in_byte)) begin
                     slot_c[1].data = upc_pkg::plain_byte(req_in_byte);
                     n_c = 2'd2;
                  end else begin
                     phase_in = PH_PERCENT;
                  end
               end
            end
            PH_DIGIT: begin
               if (upc_pkg::is_hex(req_in_byte)) begin
                  slot_c[0].data = {upc_pkg::hex_value(held_ff),
                                    upc_pkg::hex_value(req_in_byte)};
                  n_c = 2'd1;
               end else begin
                  // held digit is always hex, so it passes through as itself
                  slot_c[0].data = upc_pkg::CHAR_PERCENT;
                  slot_c[0].bad  = 1'b1;
                  slot_c[1].data = held_ff;
                  n_c = 2'd2;
                  if (upc_pkg::plain_emits(req_in_byte)) begin
                     slot_c[2].data = upc_pkg::plain_byte(req_in_byte);
                     n_c = 2'd3;
                  end else begin
                     phase_in = PH_PERCENT;
                  end
               end
            end
            default: begin
               if (upc_pkg::plain_emits(req_in_byte)) begin
                  slot_c[0].data = upc_pkg::plain_byte(req_in_byte);
                  n_c = 2'd1;
               end else begin
                  phase_in = PH_PERCENT;
               end
            end
         endcase
         // end of string flushes any pending escape
         if (req_in_last) begin
            if (phase_in == PH_PERCENT || phase_in == PH_DIGIT) begin
               slot_c[n_c].data = upc_pkg::CHAR_PERCENT;
               slot_c[n_c].bad  = 1'b1;
               n_c = 2'(n_c + 2'd1);
            end
            if (phase_in == PH_DIGIT) begin
               slot_c[n_c].data = held_in;
               n_c = 2'(n_c + 2'd1);
            end
            phase_in = PH_NONE;
         end
      end
      if (req_in_last && n_c != 2'd0) slot_c[2'(n_c - 2'd1)].last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NONE;
         held_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   assign q_push = accept && (n_c != 2'd0);

   always_comb begin
      for (int i = 0; i < upc_pkg::SLOTS; i++) q_bundle.slot[i] = slot_c[i];
      q_bundle.count = n_c;
   end

endmodule

`default_nettype wire

// ----- hdl/upc_queue.sv -----
// Short bundle queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module upc_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  upc_pkg::bundle_type      push_bundle,
   output logic                     full,
   input  wire logic                pop,
   output upc_pkg::bundle_type      head,
   output logic                     empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   upc_pkg::bundle_type store [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      if (do_push && !do_pop)      count_in = CNT_W'(count_ff + 1'b1);
      else if (do_pop && !do_push) count_in = CNT_W'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (do_push) store[wr_ptr_ff] <= push_bundle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/upc_back.sv -----
// Back end: bundles enter the result register one byte per unstalled cycle.
`timescale 1ns / 1ps
`default_nettype none

module upc_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  upc_pkg::bundle_type  head,
   input  wire logic            q_empty,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  wire logic            rsp_pop,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_out_last,
   output logic                 rsp_bad_escape
);

   logic [upc_pkg::COUNT_W-1:0] idx_ff, idx_in;
   logic                        valid_ff, valid_in;
   upc_pkg::result_type         out_ff, out_in;
   logic                        load, at_end;

   assign load   = !q_empty && (!valid_ff || rsp_pop);
   assign at_end = (idx_ff == upc_pkg::COUNT_W'(head.count - 1'b1));
   assign q_pop  = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      if (load) begin
         out_in   = head.slot[idx_ff];
         valid_in = 1'b1;
         idx_in   = at_end ? '0 : upc_pkg::COUNT_W'(idx_ff + 1'b1);
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty      = !valid_ff;
   assign rsp_out_byte   = out_ff.data;
   assign rsp_out_last   = out_ff.last;
   assign rsp_bad_escape = out_ff.bad;

endmodule

`default_nettype wire

// ----- hdl/url_percent_codec_unit.sv -----
// Top level of the streaming URL percent encoder / decoder.
// Usage:
//   req_ channel (queue style): drive req_in_byte/req_in_last and raise req_push;
//   the byte transfers on a clock edge with req_push high and req_full low.
//   rsp_ channel: while rsp_empty is low the oldest result sits on rsp_out_byte,
//   rsp_out_last and rsp_bad_escape; it transfers on an edge with rsp_pop high.
//   csr_ channel: csr_index 0 = decode_mode, 1 = upper_hex, value in csr_data;
//   csr_ready is always high. Write only while the codec is idle.
// Timing:
//   The first result of a byte is on the rsp_ ports right after the edge that
//   follows its transfer unless bundles wait ahead or the result stalls; the
//   others follow one per cycle while rsp_pop is high. Input bytes are taken
//   every cycle while the bundle queue has room; the output side moves one
//   byte per cycle while popped, so an encoded byte that expands to '%hh'
//   needs three outputs; the single-byte result register sets the sustained rate.
// Reset: queue and result register empty, no escape pending, encode mode,
//   uppercase hex.
// Backpressure: when rsp_pop stays low the result holds, the queue fills
//   (QUEUE_DEPTH bundles) and req_full rises; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module url_percent_codec_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic [7:0]                        req_in_byte,
   input  wire logic                              req_in_last,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [7:0]                             rsp_out_byte,
   output logic                                   rsp_out_last,
   output logic                                   rsp_bad_escape,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [upc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic                              csr_data
);

   // front -> queue -> back
   upc_pkg::bundle_type push_bundle, head;
   logic q_push, q_full, q_pop, q_empty;

   upc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_bundle    (push_bundle)
   );

   upc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (q_push),
      .push_bundle (push_bundle),
      .full        (q_full),
      .pop         (q_pop),
      .head        (head),
      .empty       (q_empty)
   );

   upc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last),
      .rsp_bad_escape (rsp_bad_escape)
   );

endmodule

`default_nettype wire

// ----- hdl/upc_checker.sv -----
// Port-level checker for the URL percent codec, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module upc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_full,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_out_last,
   input wire logic       rsp_bad_escape,
   input wire logic       csr_ready
);

   // reset leaves both sides empty
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("codec not empty after reset");

   // a flagged result is always the literal percent sign
   a_bad_is_percent: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_bad_escape) |-> (rsp_out_byte == upc_pkg::CHAR_PERCENT))
      else $error("bad_escape on a byte other than percent");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_out_byte) && $stable(rsp_out_last) &&
          $stable(rsp_bad_escape)))
      else $error("result changed while stalled");

   // config port never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr_ready dropped");

endmodule

bind url_percent_codec_unit upc_checker u_upc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_out_last   (rsp_out_last),
   .rsp_bad_escape (rsp_bad_escape),
   .csr_ready      (csr_ready)
);

`default_nettype wire

// ----- tb/url_codec_checker.sv -----
// Checker for the URL percent codec: tracks config, predicts results per byte, compares pops.
`timescale 1ns / 1ps

module url_codec_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  logic                            req_full,
   input  logic [7:0]                      req_in_byte,
   input  logic                            req_in_last,
   input  logic                            rsp_empty,
   input  logic                            rsp_pop,
   input  logic [7:0]                      rsp_out_byte,
   input  logic                            rsp_out_last,
   input  logic                            rsp_bad_escape,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [upc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic                            csr_data,
   output int unsigned                     error_count,
   output int unsigned                     pending_count
);

   typedef enum logic [1:0] {
      ESC_IDLE  = 2'd0,
      ESC_OPEN  = 2'd1,
      ESC_DIGIT = 2'd2
   } esc_phase_type;

   logic          mode_decode;
   logic          upper_digits;
   esc_phase_type esc_state;
   logic [7:0]    first_digit;

   upc_pkg::result_type awaited_bytes[$];
   upc_pkg::result_type step_bytes[$];

   function automatic logic is_hex_char(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      if (c <= 8'h39) begin
         return 4'(c - 8'h30);
      end else if (c <= 8'h46) begin
         return 4'(c - 8'h37);
      end
      return 4'(c - 8'h57);
   endfunction

   function automatic logic is_unreserved(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == upc_pkg::CHAR_DOT ||
             c == upc_pkg::CHAR_DASH || c == upc_pkg::CHAR_UNDERSCORE ||
             c == upc_pkg::CHAR_TILDE;
   endfunction

   function automatic logic [7:0] hex_glyph(input logic [3:0] nib, input logic upper);
      if (nib < 4'd10) begin
         return 8'h30 + {4'h0, nib};
      end
      return (upper ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10;
   endfunction

   // at most three bytes per input; anything beyond is dropped
   task automatic emit_byte(input logic [7:0] value, input logic flagged);
      upc_pkg::result_type r;
      if (step_bytes.size() < upc_pkg::SLOTS) begin
         r.data = value;
         r.last = 1'b0;
         r.bad  = flagged;
         step_bytes = {step_bytes, r};
      end
   endtask

   task automatic decode_plain(input logic [7:0] value);
      if (value == upc_pkg::CHAR_PERCENT) begin
         esc_state = ESC_OPEN;
      end else begin
         emit_byte((value == upc_pkg::CHAR_PLUS) ? upc_pkg::CHAR_SPACE : value, 1'b0);
      end
   endtask

   task automatic percent_codec_step(input logic [7:0] value, input logic last_flag);
      upc_pkg::result_type r;
      step_bytes.delete();
      if (!mode_decode) begin
         esc_state = ESC_IDLE;
         if (is_unreserved(value)) begin
            emit_byte(value, 1'b0);
         end else begin
            emit_byte(upc_pkg::CHAR_PERCENT, 1'b0);
            emit_byte(hex_glyph(value[7:4], upper_digits), 1'b0);
            emit_byte(hex_glyph(value[3:0], upper_digits), 1'b0);
         end
      end else begin
         case (esc_state)
            ESC_OPEN: begin
               if (is_hex_char(value)) begin
                  first_digit = value;
                  esc_state   = ESC_DIGIT;
               end else begin
                  esc_state = ESC_IDLE;
                  emit_byte(upc_pkg::CHAR_PERCENT, 1'b1);
                  decode_plain(value);
               end
            end
            ESC_DIGIT: begin
               esc_state = ESC_IDLE;
               if (is_hex_char(value) && is_hex_char(first_digit)) begin
                  emit_byte({nibble_of(first_digit), nibble_of(value)}, 1'b0);
               end else begin
                  emit_byte(upc_pkg::CHAR_PERCENT, 1'b1);
                  decode_plain(first_digit);
                  decode_plain(value);
               end
            end
            default: begin
               esc_state = ESC_IDLE;
               decode_plain(value);
            end
         endcase
         // dangling escape gets flushed literally at end of string
         if (last_flag) begin
            if (esc_state == ESC_OPEN) begin
               emit_byte(upc_pkg::CHAR_PERCENT, 1'b1);
            end else if (esc_state == ESC_DIGIT) begin
               emit_byte(upc_pkg::CHAR_PERCENT, 1'b1);
               emit_byte(first_digit, 1'b0);
            end
            esc_state = ESC_IDLE;
         end
      end
      foreach (step_bytes[i]) begin
         r = step_bytes[i];
         r.last = last_flag && (i == step_bytes.size() - 1);
         awaited_bytes = {awaited_bytes, r};
      end
   endtask

   task automatic log_miss(input string what, input upc_pkg::result_type want,
                           input upc_pkg::result_type got);
      error_count++;
      if (error_count <= 10) begin
         $display("%t %s: expected byte %02h last %0b bad %0b, got byte %02h last %0b bad %0b",
                  $realtime, what, want.data, want.last, want.bad,
                  got.data, got.last, got.bad);
      end
   endtask

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      upc_pkg::result_type want;
      upc_pkg::result_type got;
      if (reset) begin
         awaited_bytes.delete();
         mode_decode  = 1'b0;
         upper_digits = 1'b1;
         esc_state    = ESC_IDLE;
         first_digit  = 8'h00;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               upc_pkg::REG_DECODE_MODE: mode_decode  = csr_data;
               upc_pkg::REG_UPPER_HEX:   upper_digits = csr_data;
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            percent_codec_step(req_in_byte, req_in_last);
         end
         if (rsp_pop && !rsp_empty) begin
            got.data = rsp_out_byte;
            got.last = rsp_out_last;
            got.bad  = rsp_bad_escape;
            if (awaited_bytes.size() == 0) begin
               want = '0;
               log_miss("result with nothing pending", want, got);
            end else begin
               want = awaited_bytes.pop_front();
               if (got.data !== want.data || got.last !== want.last ||
                   got.bad !== want.bad) begin
                  log_miss("result mismatch", want, got);
               end
            end
         end
      end
      pending_count = awaited_bytes.size();
   end

endmodule

// ----- tb/testbench.sv -----
// Top of the URL percent codec testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module testbench;

   // Hard cycle limit for the run; this leaves a wide margin
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned ITEM_TARGET  = 260;
   // Results pass the queue and the result register; bytes that open an escape
   // produce nothing, so let the pipeline settle before a csr write
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned LONG_HOLD     = 300;

   logic                            clock        = 1'b0;
   logic                            reset        = 1'b1;
   logic                            req_push     = 1'b0;
   logic [7:0]                      req_in_byte  = 8'h00;
   logic                            req_in_last  = 1'b0;
   logic                            rsp_pop      = 1'b0;
   logic                            csr_valid    = 1'b0;
   logic [upc_pkg::CSR_INDEX_W-1:0] csr_index    = upc_pkg::REG_DECODE_MODE;
   logic                            csr_data     = 1'b0;
   logic                            req_full;
   logic                            rsp_empty;
   logic [7:0]                      rsp_out_byte;
   logic                            rsp_out_last;
   logic                            rsp_bad_escape;
   logic                            csr_ready;

   int unsigned failures;
   int unsigned awaiting;
   int unsigned cycle_count     = 0;
   int unsigned items_sent      = 0;
   int unsigned req_gap_max     = 0;
   int unsigned rsp_gap_max     = 0;
   // Set by the stimulus, consumed by the receiver: one long pop hold-off
   int unsigned rsp_hold_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   url_percent_codec_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last),
      .rsp_bad_escape (rsp_bad_escape),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   url_codec_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last),
      .rsp_bad_escape (rsp_bad_escape),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .error_count    (failures),
      .pending_count  (awaiting)
   );

   // Hard stop in case the codec hangs or swallows a result
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver: random gap before every pop, or the long hold-off when asked.
   // pop stays high across back-to-back transfers.
   initial begin : rsp_side
      int unsigned gap;
      wait (!reset);
      forever begin
         if (rsp_hold_cycles != 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            gap = $urandom_range(0, rsp_gap_max);
         end
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   // One byte transfer on the req_ side, after a random gap. push is left
   // high so a following zero-gap byte goes out on the very next edge unless req_full is high.
   task automatic send_byte(input logic [7:0] value, input logic last_flag);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_in_byte <= value;
      req_in_last <= last_flag;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   // Stop sending and wait for every predicted result; the checker updates
   // its count at the edge, so look at it on the falling edge.
   task automatic drain_and_settle();
      req_push <= 1'b0;
      do @(negedge clock); while (awaiting != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers in one burst; valid stays high between the two transfers
   task automatic write_config(input logic decode_bit, input logic upper_bit);
      csr_valid <= 1'b1;
      csr_index <= upc_pkg::REG_DECODE_MODE;
      csr_data  <= decode_bit;
      do @(posedge clock); while (!csr_ready);
      csr_index <= upc_pkg::REG_UPPER_HEX;
      csr_data  <= upper_bit;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_hex();
      string digits;
      digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(0, 21)];
   endfunction

   // Encode strings: mostly arbitrary bytes, some letters to exercise pass-through
   task automatic send_encode_string(input int unsigned span);
      logic [7:0] value;
      for (int unsigned i = 0; i < span; i++) begin
         if ($urandom_range(0, 2) == 0) begin
            value = 8'($urandom_range(8'h41, 8'h5A)) | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
         end else begin
            value = 8'($urandom_range(0, 255));
         end
         send_byte(value, i == span - 1);
      end
   endtask

   // Decode strings: mostly well-formed %hh escapes with random case, mixed
   // with '+', plain and arbitrary bytes, broken escapes and dangling ones.
   task automatic send_decode_string(input int unsigned span);
      logic [7:0] text[$];
      while (text.size() < span) begin
         case ($urandom_range(0, 11))
            0, 1, 2, 3, 4: begin
               text = {text, upc_pkg::CHAR_PERCENT, pick_hex(), pick_hex()};
            end
            5: text = {text, upc_pkg::CHAR_PLUS};
            6: text = {text, 8'($urandom_range(8'h61, 8'h7A))};
            7: text = {text, 8'($urandom_range(0, 255))};
            8: begin
               // escape broken at the first digit (unless the byte happens to be hex)
               text = {text, upc_pkg::CHAR_PERCENT, 8'($urandom_range(0, 255))};
            end
            9: begin
               text = {text, upc_pkg::CHAR_PERCENT, pick_hex(), 8'($urandom_range(0, 255))};
            end
            10: text = {text, upc_pkg::CHAR_PERCENT};
            default: begin
               text = {text, upc_pkg::CHAR_PERCENT, pick_hex()};
            end
         endcase
      end
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   initial begin : stimulus
      logic [7:0]  enc_probe [9];
      int unsigned phase;
      int unsigned strings;
      logic        decode_bit;
      logic        upper_bit;

      enc_probe = '{8'h00, "Z", "a", "0", upc_pkg::CHAR_DOT, upc_pkg::CHAR_DASH,
                    upc_pkg::CHAR_UNDERSCORE, upc_pkg::CHAR_TILDE, 8'hFF};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part, back to back ----
      // Encode, uppercase: boundary bytes and every unreserved punctuation mark
      write_config(1'b0, 1'b1);
      foreach (enc_probe[i]) send_byte(enc_probe[i], i == 8);

      // Encode, lowercase: letters a-f in the escape
      drain_and_settle();
      write_config(1'b0, 1'b0);
      send_byte(8'hAB, 1'b1);

      // Decode: valid escape, plus, bad first digit, bad second digit
      // followed by '+', dangling escape with a digit
      drain_and_settle();
      write_config(1'b1, 1'b0);
      send_byte(upc_pkg::CHAR_PERCENT, 1'b0);
      send_byte("4", 1'b0);
      send_byte("1", 1'b0);
      send_byte(upc_pkg::CHAR_PLUS, 1'b0);
      send_byte(upc_pkg::CHAR_PERCENT, 1'b0);
      send_byte("g", 1'b0);
      send_byte(upc_pkg::CHAR_PERCENT, 1'b0);
      send_byte("4", 1'b0);
      send_byte(upc_pkg::CHAR_PLUS, 1'b0);
      send_byte(upc_pkg::CHAR_PERCENT, 1'b0);
      send_byte("f", 1'b1);
      // zero byte as data, then a bare dangling '%'
      send_byte(8'h00, 1'b0);
      send_byte(upc_pkg::CHAR_PERCENT, 1'b1);

      // Leave an escape open, then switch to encode: it must be dropped
      send_byte(upc_pkg::CHAR_PERCENT, 1'b0);
      drain_and_settle();
      write_config(1'b0, 1'b1);
      send_byte("A", 1'b1);

      // ---- random part: one config per phase ----
      // First four phases walk all register combinations; later ones are random.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain_and_settle();
         if (phase < 4) begin
            decode_bit = phase[0];
            upper_bit  = phase[1];
         end else begin
            decode_bit = 1'($urandom_range(0, 1));
            upper_bit  = 1'($urandom_range(0, 1));
         end
         write_config(decode_bit, upper_bit);

         // Phase 0 runs without idling, others pick 0 or 17 per side
         if (phase == 0) begin
            req_gap_max = 0;
            rsp_gap_max = 0;
         end else begin
            req_gap_max = $urandom_range(0, 1) * 17;
            rsp_gap_max = $urandom_range(0, 1) * 17;
         end

         // Backpressure phase: receiver holds off while bytes keep coming,
         // so the bundle queue fills and req_full must rise
         strings = $urandom_range(3, 6);
         if (phase == 2) begin
            req_gap_max     = 0;
            rsp_gap_max     = 0;
            rsp_hold_cycles = LONG_HOLD;
            strings         = 10;
         end

         repeat (strings) begin
            if (items_sent < ITEM_TARGET) begin
               if (decode_bit) begin
                  send_decode_string($urandom_range(1, 10));
               end else begin
                  send_encode_string($urandom_range(1, 10));
               end
            end
         end
         phase++;
      end

      drain_and_settle();
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
